>>> rtl/ccenv_pkg.sv
// Package for the cyclic cubic envelope generator.
// Widths, register indexes and command/status types. No dependencies.
`timescale 1ns / 1ps
package ccenv_pkg;
  localparam int TimeW  = 16;
  localparam int LevelW = 16;
  localparam int SumW   = TimeW + 2;
  localparam int CoefW  = LevelW + 5;
  localparam int AccW   = 40;

  typedef enum logic [2:0] {
    RegDurA = 3'd0, RegDurB = 3'd1, RegV1 = 3'd2, RegV2 = 3'd3,
    RegV3 = 3'd4, RegV4 = 3'd5, RegV5 = 3'd6, RegNone = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic load;      // start new item: add delta, setup
    logic wrap;      // reduce time by a shifted period
    logic seg_step;  // advance segment
    logic div_init;
    logic div_step;
    logic hor_init;
    logic hor_step;
    logic finish;
  } ccenv_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic over_period;
    logic seg_more;
    logic div_done;
    logic hor_done;
  } ccenv_sts_t;
endpackage

>>> rtl/ccenv_ctrl.sv
// Controller state machine for the envelope generator.
// Depends on ccenv_pkg.
`timescale 1ns / 1ps
module ccenv_ctrl import ccenv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ccenv_sts_t sts_i,
  output ccenv_cmd_t cmd_o
);
  typedef enum logic [5:0] {
    StIdle = 6'b000001, StWrap = 6'b000010, StSeg = 6'b000100,
    StDiv  = 6'b001000, StHor  = 6'b010000, StOut = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StWrap;
        end
      end
      StWrap: begin
        if (sts_i.period_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = StOut;
        end else if (sts_i.over_period) begin
          cmd_o.wrap = 1'b1;
        end else begin
          state_d = StSeg;
        end
      end
      StSeg: begin
        if (sts_i.seg_more) begin
          cmd_o.seg_step = 1'b1;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.hor_init = 1'b1;
          state_d        = StHor;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StHor: begin
        if (sts_i.hor_done) begin
          cmd_o.finish = 1'b1;
          state_d      = StOut;
        end else begin
          cmd_o.hor_step = 1'b1;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

>>> rtl/ccenv_datapath.sv
// Datapath: config registers, time/segment state, restoring divider,
// Horner evaluator and output registers. Depends on ccenv_pkg.
`timescale 1ns / 1ps
module ccenv_datapath import ccenv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  logic [15:0]              delta_time_i,
  input  ccenv_cmd_t               cmd_i,
  output ccenv_sts_t               sts_o,
  output logic signed [LevelW-1:0] curve_value_o,
  output logic [1:0]               active_segment_o
);
  logic [31:0] dur_a_q, dur_b_q;
  logic signed [LevelW-1:0] lv_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_a_q <= '0;
      dur_b_q <= '0;
      for (int i = 0; i < 5; i++) lv_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegDurA: dur_a_q <= cfg_data_i;
        RegDurB: dur_b_q <= cfg_data_i;
        RegV1:   lv_q[0] <= cfg_data_i[LevelW-1:0];
        RegV2:   lv_q[1] <= cfg_data_i[LevelW-1:0];
        RegV3:   lv_q[2] <= cfg_data_i[LevelW-1:0];
        RegV4:   lv_q[3] <= cfg_data_i[LevelW-1:0];
        RegV5:   lv_q[4] <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  logic [TimeW-1:0] dur [4];
  assign dur[0] = dur_a_q[TimeW-1:0];
  assign dur[1] = dur_a_q[2*TimeW-1:TimeW];
  assign dur[2] = dur_b_q[TimeW-1:0];
  assign dur[3] = dur_b_q[2*TimeW-1:TimeW];

  logic [SumW-1:0] start [4];
  logic [SumW-1:0] seg_end [4];
  always_comb begin
    start[0] = '0;
    for (int k = 0; k < 4; k++) begin
      seg_end[k] = start[k] + SumW'(dur[k]);
      if (k < 3) start[k+1] = seg_end[k];
    end
  end
  logic [SumW-1:0] period;
  assign period = seg_end[3];

  logic [SumW-1:0] time_q;
  logic [1:0]      seg_q;
  logic [SumW:0]   tt_q;

  assign sts_o.period_zero = (period == '0);
  assign sts_o.over_period = (tt_q > {1'b0, period});
  assign sts_o.seg_more    = (seg_q != 2'd3) && (tt_q[SumW-1:0] > seg_end[seg_q]);

  // wrap: binary reduction, period << k for k = 16 down to 0
  logic [4:0]       wcnt_q;
  logic [SumW+16:0] wrap_sub;
  assign wrap_sub = (SumW+17)'(period) << wcnt_q;

  // divider: t = (min(num, d) << 16) / d
  localparam int QW = 17;
  logic [TimeW-1:0] dv_q;
  logic [TimeW:0]   rem_q;
  logic [QW-1:0]    quo_q;
  logic [5:0]       dcnt_q;
  logic             tfix_q;
  logic [QW-1:0]    tval_q;
  assign sts_o.div_done = (dcnt_q == 6'd0);

  logic [SumW-1:0] seg_start, num;
  assign seg_start = start[seg_q];
  assign num = tt_q[SumW-1:0] - seg_start;

  logic [TimeW+1:0] rem_sh;
  assign rem_sh = {rem_q, 1'b0};

  // Horner
  logic signed [LevelW-1:0] xp [4];
  always_comb begin
    unique case (seg_q)
      2'd0: begin xp[0]=lv_q[0]; xp[1]=lv_q[0]; xp[2]=lv_q[1]; xp[3]=lv_q[2]; end
      2'd1: begin xp[0]=lv_q[2]; xp[1]=lv_q[3]; xp[2]=lv_q[4]; xp[3]=lv_q[4]; end
      2'd2: begin xp[0]=lv_q[4]; xp[1]=lv_q[4]; xp[2]=lv_q[3]; xp[3]=lv_q[2]; end
      default: begin xp[0]=lv_q[2]; xp[1]=lv_q[1]; xp[2]=lv_q[0]; xp[3]=lv_q[0]; end
    endcase
  end
  logic signed [CoefW-1:0] cc, cb, ca, cd;
  always_comb begin
    cd = CoefW'(xp[0]);
    cc = 3 * (CoefW'(xp[1]) - CoefW'(xp[0]));
    cb = 3 * (CoefW'(xp[2]) - CoefW'(xp[1])) - cc;
    ca = CoefW'(xp[3]) - cd - cc - cb;
  end

  logic signed [AccW-1:0] r_q, prod_q;
  logic [2:0] hcnt_q;
  logic       hmul_q;
  assign sts_o.hor_done = (hcnt_q == 3'd0) && !hmul_q;

  logic signed [AccW-1:0] rsum, addend;
  assign rsum = (prod_q + AccW'(32768)) >>> 16;
  always_comb begin
    unique case (hcnt_q)
      3'd3:    addend = AccW'(cb);
      3'd2:    addend = AccW'(cc);
      default: addend = AccW'(cd);
    endcase
  end

  localparam logic signed [AccW-1:0] Hi = AccW'((1 << (LevelW-1)) - 1);
  localparam logic signed [AccW-1:0] Lo = -Hi - 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      seg_q  <= '0;
      tt_q   <= '0;
      wcnt_q <= '0;
      dv_q   <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      tfix_q <= 1'b0;
      tval_q <= '0;
      dcnt_q <= '0;
      r_q    <= '0;
      prod_q <= '0;
      hcnt_q <= '0;
      hmul_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        tt_q   <= {1'b0, time_q} + (SumW+1)'(delta_time_i);
        wcnt_q <= 5'd16;
      end
      if (cmd_i.wrap) begin
        // strict compare keeps the result in (0,P]
        if ((SumW+17)'(tt_q) > wrap_sub) tt_q <= tt_q - (SumW+1)'(wrap_sub);
        if (wcnt_q != 5'd0) wcnt_q <= wcnt_q - 5'd1;
        seg_q <= 2'd0;
      end
      if (cmd_i.seg_step) seg_q <= seg_q + 2'd1;
      if (cmd_i.div_init) begin
        time_q <= tt_q[SumW-1:0];
        dv_q   <= dur[seg_q];
        rem_q  <= '0;
        quo_q  <= '0;
        if (dur[seg_q] == '0) begin
          tfix_q <= 1'b1; tval_q <= QW'(65536); dcnt_q <= '0;
        end else if (tt_q[SumW-1:0] <= seg_start) begin
          tfix_q <= 1'b1; tval_q <= '0; dcnt_q <= '0;
        end else begin
          tfix_q <= 1'b0;
          tval_q <= (num > SumW'(dur[seg_q])) ? QW'(dur[seg_q]) : QW'(num);
          dcnt_q <= 6'd32;
        end
      end
      if (cmd_i.div_step) begin
        // dividend bits: num clamped to d (16 bits) followed by 16 zeros, MSB first
        logic bitin;
        logic [TimeW+1:0] trial;
        bitin = (dcnt_q > 6'd16) ? tval_q[5'(dcnt_q - 6'd17)] : 1'b0;
        trial = rem_sh | (TimeW+2)'(bitin);
        if (trial >= (TimeW+2)'(dv_q)) begin
          rem_q <= (TimeW+1)'(trial - (TimeW+2)'(dv_q));
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= (TimeW+1)'(trial);
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end
      if (cmd_i.hor_init) begin
        if (!tfix_q) tval_q <= quo_q;
        r_q    <= AccW'(ca);
        hcnt_q <= 3'd3;
        hmul_q <= 1'b1;
      end
      if (cmd_i.hor_step) begin
        if (hmul_q) begin
          prod_q <= r_q * $signed({1'b0, tval_q});
          hmul_q <= 1'b0;
        end else begin
          r_q    <= rsum + addend;
          hcnt_q <= hcnt_q - 3'd1;
          hmul_q <= (hcnt_q != 3'd1);
        end
      end
      if (cmd_i.finish) begin
        if (period == '0) begin
          time_q <= '0;
          seg_q  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (period == '0) begin
        curve_value_o    <= lv_q[0];
        active_segment_o <= 2'd0;
      end else begin
        curve_value_o    <= (r_q > Hi) ? LevelW'(Hi) :
                            (r_q < Lo) ? LevelW'(Lo) : LevelW'(r_q);
        active_segment_o <= seg_q;
      end
    end
  end
endmodule

>>> rtl/cyclic_cubic_envelope_generator_top.sv
// Top level of the cyclic cubic envelope generator.
// An item passes through load, up to 17 wrap steps, up to 3 segment steps,
// 32 divide steps when t needs a divide, then Horner and output; a zero
// period goes straight to output. Flow: one item at a time; the next item
// can be accepted at the edge that takes the result. Reset clears all state
// async but the output regs. Depends on ccenv_pkg, ccenv_ctrl, ccenv_datapath.
`timescale 1ns / 1ps
module cyclic_cubic_envelope_generator_top import ccenv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [15:0]              delta_time_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [LevelW-1:0] curve_value_o,
  output logic [1:0]               active_segment_o
);
  ccenv_cmd_t cmd;
  ccenv_sts_t sts;

  ccenv_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ccenv_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .delta_time_i,
    .cmd_i(cmd), .sts_o(sts), .curve_value_o, .active_segment_o
  );
endmodule

>>> rtl/ccenv_checker.sv
// Port-level checker for the envelope generator, bound to the top level.
// Depends on ccenv_pkg.
`timescale 1ns / 1ps
module ccenv_sva import ccenv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [LevelW-1:0] curve_value_o,
  input logic [1:0]        active_segment_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_value_o))
    else $error("result changed while stalled");
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too soon");
endmodule

bind cyclic_cubic_envelope_generator_top ccenv_sva u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .curve_value_o, .active_segment_o
);
